// File: rtl/core/pctdec_pkg.sv
`default_nettype none

package pctdec_pkg;

    // decoder mode codes
    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_PCT     = 2'd1,
        MODE_HEX1    = 2'd2,
        MODE_SWALLOW = 2'd3
    } decode_mode_t;

    // character codes
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;

    // decoder state carried between transactions
    typedef struct packed {
        decode_mode_t mode;
        logic [3:0]   high_nibble;
    } dec_state_t;

    // one result transaction
    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       ended;
        logic       bad_escape;
    } dec_result_t;

    // hex digit lookup
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } nibble_t;

    function automatic nibble_t hex_nibble(input logic [7:0] c);
        nibble_t    n;
        logic [7:0] diff;
        n    = '0;
        diff = '0;
        if (c inside {[CHAR_UPPER_A : CHAR_UPPER_A + 8'd5]}) begin
            diff  = c - CHAR_UPPER_A + 8'd10;
            n.ok  = 1'b1;
            n.val = diff[3:0];
        end else if (c inside {[CHAR_LOWER_A : CHAR_LOWER_A + 8'd5]}) begin
            diff  = c - CHAR_LOWER_A + 8'd10;
            n.ok  = 1'b1;
            n.val = diff[3:0];
        end else if (c inside {[CHAR_ZERO : CHAR_ZERO + 8'd9]}) begin
            diff  = c - CHAR_ZERO;
            n.ok  = 1'b1;
            n.val = diff[3:0];
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/pctdec_if.sv
`default_nettype none

// encoded byte channel
interface pctdec_enc_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// decoded result channel
interface pctdec_dec_if;
    logic       valid;
    logic       ready;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       ended;
    logic       bad_escape;

    modport source (output valid, output out_valid, output out_byte, output ended,
                    output bad_escape, input ready);
    modport sink   (input valid, input out_valid, input out_byte, input ended,
                    input bad_escape, output ready);
endinterface

`default_nettype wire

// File: rtl/core/pctdec_step.sv
`default_nettype none

module pctdec_step (
    input  var pctdec_pkg::dec_state_t  cur,
    input  wire logic [7:0]             in_byte,
    input  wire logic                   last_byte,
    output var pctdec_pkg::dec_state_t  nxt,
    output var pctdec_pkg::dec_result_t res
);

    pctdec_pkg::nibble_t nib;

    assign nib = pctdec_pkg::hex_nibble(in_byte);

    // one decode step per byte
    always_comb
    begin
        nxt = cur;
        res = '0;
        case (cur.mode)
            pctdec_pkg::MODE_NORMAL:
            begin
                if (in_byte == pctdec_pkg::CHAR_NUL) begin
                    res.ended = 1'b1;
                    nxt.mode  = pctdec_pkg::MODE_SWALLOW;
                end else if (in_byte == pctdec_pkg::CHAR_PLUS) begin
                    res.out_valid = 1'b1;
                    res.out_byte  = pctdec_pkg::CHAR_SPACE;
                end else if (in_byte == pctdec_pkg::CHAR_PERCENT) begin
                    nxt.mode = pctdec_pkg::MODE_PCT;
                end else begin
                    res.out_valid = 1'b1;
                    res.out_byte  = in_byte;
                end
            end
            pctdec_pkg::MODE_PCT:
            begin
                // on the last byte the escape is cut short, no error
                if (!last_byte) begin
                    if (nib.ok) begin
                        nxt.high_nibble = nib.val;
                        nxt.mode        = pctdec_pkg::MODE_HEX1;
                    end else begin
                        res.ended      = 1'b1;
                        res.bad_escape = 1'b1;
                        nxt.mode       = pctdec_pkg::MODE_SWALLOW;
                    end
                end
            end
            pctdec_pkg::MODE_HEX1:
            begin
                if (nib.ok) begin
                    res.out_valid = 1'b1;
                    res.out_byte  = {cur.high_nibble, nib.val};
                    nxt.mode      = pctdec_pkg::MODE_NORMAL;
                end else begin
                    res.ended      = 1'b1;
                    res.bad_escape = 1'b1;
                    nxt.mode       = pctdec_pkg::MODE_SWALLOW;
                end
            end
            default:
            begin
                // swallowing until the last byte
            end
        endcase

        // last byte ends any live decode and restarts
        if (last_byte) begin
            if (cur.mode != pctdec_pkg::MODE_SWALLOW) begin
                res.ended = 1'b1;
            end
            nxt.mode        = pctdec_pkg::MODE_NORMAL;
            nxt.high_nibble = '0;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/percent_decoder.sv
// percent_decoder: streaming form-urlencoded decoder, one byte per transaction.
// enc channel: one raw byte (in_byte) and last_byte marking the buffer's end.
// dec channel: exactly one result per accepted byte: out_valid/out_byte carry
// a decoded byte, ended flags the byte that ends decoding (zero byte,
// truncated escape, bad escape or last byte), bad_escape flags a non-hex
// digit after a percent. After decoding ends, bytes give empty results until
// the last byte, which returns the decoder to its start state.
// The result is registered and appears in the cycle after the byte is accepted.
// Throughput: one byte per cycle unless stalled; the mode and nibble registers
// are updated by a single short decode step, so bytes may follow back to back.
// A single result register sits between the channels; enc.ready is high
// whenever that register is empty or being drained in the same cycle.
// When the receiver stalls, the result holds and enc.ready falls until the
// result is taken; no transaction is lost or repeated.
// Reset (rst_n low, asynchronous) empties the result register and returns
// the decoder to normal mode with a cleared high nibble.
`default_nettype none

module percent_decoder (
    input  wire logic         clk,
    input  wire logic         rst_n,
    pctdec_enc_if.sink        enc,
    pctdec_dec_if.source      dec
);

    pctdec_pkg::dec_state_t  state_reg;
    pctdec_pkg::dec_state_t  state_next;
    pctdec_pkg::dec_result_t res_reg;
    pctdec_pkg::dec_result_t res_next;
    logic                    valid_reg;
    logic                    accept;

    // handshake
    assign enc.ready = !valid_reg || dec.ready;
    assign accept    = enc.valid && enc.ready;

    pctdec_step u_step (
        .cur       (state_reg),
        .in_byte   (enc.in_byte),
        .last_byte (enc.last_byte),
        .nxt       (state_next),
        .res       (res_next)
    );

    // decoder state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg.mode        <= pctdec_pkg::MODE_NORMAL;
            state_reg.high_nibble <= '0;
            valid_reg             <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
                valid_reg <= 1'b1;
            end else if (dec.ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    assign dec.valid      = valid_reg;
    assign dec.out_valid  = res_reg.out_valid;
    assign dec.out_byte   = res_reg.out_byte;
    assign dec.ended      = res_reg.ended;
    assign dec.bad_escape = res_reg.bad_escape;

endmodule

`default_nettype wire

// File: rtl/core/pctdec_checker.sv
`default_nettype none

module pctdec_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       enc_valid,
    input wire logic       enc_ready,
    input wire logic       dec_valid,
    input wire logic       dec_ready,
    input wire logic       out_valid,
    input wire logic [7:0] out_byte,
    input wire logic       ended,
    input wire logic       bad_escape
);

    // an accepted byte shows its result in the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (enc_valid && enc_ready) |=> dec_valid)
        else $error("result missing one cycle after accepted byte");

    // an empty result register never blocks the input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !dec_valid |-> enc_ready)
        else $error("input stalled with empty result register");

    // a bad escape always ends decoding
    a_bad_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (dec_valid && bad_escape) |-> ended)
        else $error("bad_escape without ended");

    // no decoded byte means a zero byte field
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (dec_valid && !out_valid) |-> (out_byte == 8'h00))
        else $error("out_byte nonzero without out_valid");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (dec_valid && !dec_ready) |=>
            (dec_valid && $stable(out_valid) && $stable(out_byte)
             && $stable(ended) && $stable(bad_escape)))
        else $error("stalled result changed");

endmodule

bind percent_decoder pctdec_checker u_pctdec_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .enc_valid  (enc.valid),
    .enc_ready  (enc.ready),
    .dec_valid  (dec.valid),
    .dec_ready  (dec.ready),
    .out_valid  (dec.out_valid),
    .out_byte   (dec.out_byte),
    .ended      (dec.ended),
    .bad_escape (dec.bad_escape)
);

`default_nettype wire
